/* rtl/jls_pkg.sv */
`timescale 1ns / 1ps

package jls_pkg;

  // event kinds
  localparam logic [1:0] FUNC_SUBMIT  = 2'd0;
  localparam logic [1:0] FUNC_START   = 2'd1;
  localparam logic [1:0] FUNC_DONE    = 2'd2;
  localparam logic [1:0] FUNC_INVALID = 2'd3;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] MIN_DURATION_RESET = 32'd3600;

  // divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]       func;
    logic [CNT_W-1:0] submit_time;
    logic [CNT_W-1:0] start_time;
    logic [CNT_W-1:0] end_time;
  } jls_event_t;

  typedef struct packed {
    logic [CNT_W-1:0] requests;
    logic [CNT_W-1:0] finished;
    logic [CNT_W-1:0] in_progress;
    logic [CNT_W-1:0] mean_service;
    logic [CNT_W-1:0] mean_wait;
    logic [CNT_W-1:0] longest;
    logic [CNT_W-1:0] shortest;
    logic [SUM_W-1:0] service_total;
    logic             error;
  } jls_stats_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_RESP
  } jls_state_t;

endpackage

/* rtl/jls_if.sv */
`timescale 1ns / 1ps

// event request channel
interface jls_evt_if import jls_pkg::*; ();
  logic       valid;
  logic       ready;
  jls_event_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// statistics request channel
interface jls_stat_if import jls_pkg::*; ();
  logic       valid;
  logic       ready;
  jls_stats_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/job_latency_statistics_top.sv */
`timescale 1ns / 1ps

// Job-latency statistics monitor. Each event request (submit, start, done or
// invalid) updates the counters, totals and extremes (an invalid one only sets
// the error flag) and yields one request on the stat channel carrying the
// statistics as they stand after the event. Submit, start and invalid events
// offer their result the cycle after acceptance. A done event recomputes both
// means on one shared restoring divider, one quotient bit per cycle: a load
// state then the step states per mean, service mean first, then wait mean.
// A mean whose quotient would pass 32 bits saturates in its load state and
// skips its step states. A new event is accepted only once the previous
// result has been taken, so a waiting result holds off the next event.
module job_latency_statistics_top
  import jls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  jls_evt_if.sink     evt,
  jls_stat_if.source  stat
);

  jls_state_t state, state_next;

  logic [CNT_W-1:0] request_count, done_count, active_count;
  logic [SUM_W-1:0] service_sum, wait_sum;
  logic [CNT_W-1:0] service_mean, wait_mean;
  logic [CNT_W-1:0] max_duration, min_duration;
  logic             err;

  logic                 div_sel;   // 0 service mean, 1 wait mean
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic evt_accept;
  logic stat_accept;

  assign evt_accept  = evt.valid && evt.ready;
  assign stat_accept = stat.valid && stat.ready;

  // event arithmetic
  logic [CNT_W-1:0] wait_diff, dur;
  logic [SUM_W:0]   wait_sum_add, service_sum_add;
  logic [SUM_W-1:0] wait_sum_next, service_sum_next;

  always_comb begin
    wait_diff = (evt.data.start_time >= evt.data.submit_time) ?
                (evt.data.start_time - evt.data.submit_time) : '0;
    dur = (evt.data.end_time >= evt.data.submit_time) ?
          (evt.data.end_time - evt.data.submit_time) : '0;
    wait_sum_add = {1'b0, wait_sum} + {{(SUM_W-CNT_W+1){1'b0}}, wait_diff};
    service_sum_add = {1'b0, service_sum} + {{(SUM_W-CNT_W+1){1'b0}}, dur};
    wait_sum_next = wait_sum_add[SUM_W] ? SUM_MAX : wait_sum_add[SUM_W-1:0];
    service_sum_next = service_sum_add[SUM_W] ? SUM_MAX : service_sum_add[SUM_W-1:0];
  end

  // shared divider step
  logic [SUM_W-1:0] div_dividend;
  logic             div_sat;
  logic [CNT_W:0]   trial;
  logic [CNT_W-1:0] trial_sub;
  logic             trial_ge;
  logic [CNT_W-1:0] rem_next, quo_next;
  logic             div_last;

  always_comb begin
    div_dividend = div_sel ? wait_sum : service_sum;
    div_sat      = div_dividend[SUM_W-1:CNT_W] >= done_count[SUM_W-CNT_W-1:0]
                   && done_count[CNT_W-1:SUM_W-CNT_W] == '0;
    trial     = {rem, quo[CNT_W-1]};
    trial_sub = trial[CNT_W-1:0] - done_count;
    trial_ge  = trial >= {1'b0, done_count};
    rem_next  = trial_ge ? trial_sub : trial[CNT_W-1:0];
    quo_next  = {quo[CNT_W-2:0], trial_ge};
    div_last  = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (evt_accept) begin
          state_next = (evt.data.func == FUNC_DONE) ? ST_DIV_LOAD : ST_RESP;
        end
      end
      ST_DIV_LOAD: begin
        if (!div_sat) begin
          state_next = ST_DIV_RUN;
        end else if (div_sel) begin
          state_next = ST_RESP;
        end
      end
      ST_DIV_RUN: begin
        if (div_last) begin
          state_next = div_sel ? ST_RESP : ST_DIV_LOAD;
        end
      end
      ST_RESP: begin
        if (stat_accept) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: handshake outputs
  always_comb begin
    evt.ready  = 1'b0;
    stat.valid = 1'b0;
    unique case (state)
      ST_IDLE:     evt.ready = 1'b1;
      ST_RESP:     stat.valid = 1'b1;
      ST_DIV_LOAD,
      ST_DIV_RUN:  ;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      request_count <= '0;
      done_count    <= '0;
      active_count  <= '0;
      service_sum   <= '0;
      wait_sum      <= '0;
      service_mean  <= '0;
      wait_mean     <= '0;
      max_duration  <= '0;
      min_duration  <= MIN_DURATION_RESET;
      err           <= 1'b0;
      div_sel       <= 1'b0;
    end else begin
      if (evt_accept) begin
        err     <= 1'b0;
        div_sel <= 1'b0;
        unique case (evt.data.func)
          FUNC_SUBMIT: begin
            if (request_count != CNT_MAX) request_count <= request_count + 1'b1;
          end
          FUNC_START: begin
            if (active_count != CNT_MAX) active_count <= active_count + 1'b1;
            wait_sum <= wait_sum_next;
          end
          FUNC_DONE: begin
            if (done_count != CNT_MAX) done_count <= done_count + 1'b1;
            if (active_count != '0) active_count <= active_count - 1'b1;
            service_sum <= service_sum_next;
            if (dur < min_duration) min_duration <= dur;
            if (dur > max_duration) max_duration <= dur;
          end
          default: err <= 1'b1;
        endcase
      end
      // saturated quotient settles at load
      if (state == ST_DIV_LOAD && div_sat) begin
        if (div_sel) wait_mean <= CNT_MAX;
        else         service_mean <= CNT_MAX;
        div_sel <= 1'b1;
      end
      if (state == ST_DIV_RUN && div_last) begin
        if (div_sel) wait_mean <= quo_next;
        else         service_mean <= quo_next;
        div_sel <= 1'b1;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state == ST_DIV_LOAD) begin
      rem     <= {{(2*CNT_W-SUM_W){1'b0}}, div_dividend[SUM_W-1:CNT_W]};
      quo     <= div_dividend[CNT_W-1:0];
      div_cnt <= '0;
    end else if (state == ST_DIV_RUN) begin
      rem     <= rem_next;
      quo     <= quo_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // result payload
  assign stat.data.requests      = request_count;
  assign stat.data.finished      = done_count;
  assign stat.data.in_progress   = active_count;
  assign stat.data.mean_service  = service_mean;
  assign stat.data.mean_wait     = wait_mean;
  assign stat.data.longest       = max_duration;
  assign stat.data.shortest      = min_duration;
  assign stat.data.service_total = service_sum;
  assign stat.data.error         = err;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(evt.ready && stat.valid))
    else $error("event taken while a result is pending");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_RUN |-> rem < done_count)
    else $error("divider remainder not below divisor");

  a_done_counts: assert property (@(posedge clk) disable iff (rst)
    evt_accept && evt.data.func == FUNC_DONE && done_count != CNT_MAX
    |=> done_count == $past(done_count) + 1'b1)
    else $error("done event not counted");

  a_invalid_holds: assert property (@(posedge clk) disable iff (rst)
    evt_accept && evt.data.func == FUNC_INVALID
    |=> $stable(request_count) && $stable(done_count) && $stable(active_count)
        && $stable(service_sum) && $stable(wait_sum) && err)
    else $error("invalid event changed the statistics");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    done_count != '0 |-> min_duration <= max_duration)
    else $error("shortest above longest");

endmodule
